FILE: sv/assert_macros.svh
// Assertion macros shared by the blend RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define AOB_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define AOB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/aob_pkg.sv
// Shared constants and helpers for the ARGB source-over blend.
// Depends on nothing; used by aob_qdiv and argb_over_blend.
package aob_pkg;

    localparam int NUM_W      = 17;
    localparam int DIV_STAGES = 4;
    localparam logic [7:0]  CH_MAX      = 8'hff;
    // 0x8081 / 2^23 overestimates 1/255 by under one part in 66000
    localparam logic [15:0] RECIP_255   = 16'h8081;
    localparam int          RECIP_SHIFT = 23;

    // Exact floor(x / 255) for x up to 255 * 255
    function automatic logic [7:0] div255_16(input logic [15:0] x);
        logic [15:0] sum;
        sum = x + {8'b0, x[15:8]} + 16'd1;
        return sum[15:8];
    endfunction

endpackage

FILE: sv/argb_over_blend.sv
// Source-over compositing of one non-premultiplied ARGB8888 pixel per clock while the output is not stalled.
// Depends on aob_pkg, aob_qdiv and assert_macros.svh.
//
// Usage:
//   Input channel s_valid/s_ready carries a request of source pixel,
//   destination pixel and global alpha. Output channel m_valid/m_ready
//   carries the blended pixel. Both use a plain valid/ready handshake.
//   Source alpha is scaled by global alpha; a zero result passes the
//   destination pixel through unchanged. Otherwise alpha and each color
//   channel are blended and each channel saturates at 255.
// Stages and throughput:
//   Nine register stages: a product stage, three multiply and divide-by-255
//   stages, a sum stage and four stages of the two-bit-per-step color
//   divider. Each result is driven to the m_ side straight from the last
//   divider stage. One request is accepted per clock when the receiver
//   keeps m_ready high.
// Reset and stall:
//   Synchronous active-low aresetn empties every stage. When the receiver
//   holds m_ready low with a result waiting, the whole pipeline freezes and
//   s_ready drops; nothing is lost or repeated. While no result waits, the
//   pipeline advances whatever the level of m_ready.
`include "assert_macros.svh"

module argb_over_blend (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_src_pixel,
    input  logic [31:0] s_dst_pixel,
    input  logic [7:0]  s_global_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_pixel
);
    import aob_pkg::*;

    localparam int NCH = 3;

    logic pipe_en;

    // Stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic sv_reg [DIV_STAGES];

    // Stage 1: alpha product
    logic [15:0] prod1_reg;
    logic [23:0] src1_reg;
    logic [31:0] dst1_reg;

    // Stage 2: effective alpha and destination weight
    logic [7:0]  alpha2_reg;
    logic [15:0] dainv2_reg;
    logic [15:0] sp2_reg [NCH];
    logic [31:0] dst2_reg;
    logic [7:0]  alpha2;
    logic [7:0]  inv2;

    // Stage 3: output alpha and destination channel products
    logic        byp3_reg;
    logic [7:0]  oa3_reg;
    logic [23:0] dp3_reg [NCH];
    logic [15:0] sp3_reg [NCH];
    logic [31:0] dst3_reg;
    logic [8:0]  oa_sum;

    // Stage 4: reciprocal estimates of dp / 255
    logic        byp4_reg;
    logic [7:0]  oa4_reg;
    logic [15:0] est4_reg [NCH];
    logic [23:0] dp4_reg [NCH];
    logic [15:0] sp4_reg [NCH];
    logic [31:0] dst4_reg;

    // Stage 5: numerators and divisor
    logic [NUM_W-1:0] num5_reg [NCH];
    logic [7:0]       dv5_reg;
    logic             byp5_reg;
    logic [7:0]       oa5_reg;
    logic [31:0]      dst5_reg;

    // Side pipe alongside the divider
    logic        sbyp_reg [DIV_STAGES];
    logic [7:0]  soa_reg  [DIV_STAGES];
    logic [31:0] sdst_reg [DIV_STAGES];

    logic [15:0] dterm4 [NCH];
    logic [23:0] dback4 [NCH];
    logic [7:0]  q_out  [NCH];

    // Freeze everything while a finished result waits
    assign m_valid = sv_reg[DIV_STAGES-1];
    assign pipe_en = !m_valid || m_ready;
    assign s_ready = pipe_en;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++) begin
                sv_reg[i] <= 1'b0;
            end
        end else if (pipe_en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            sv_reg[0] <= v5_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                sv_reg[i] <= sv_reg[i-1];
            end
        end
    end

    // Stage 1: scale source alpha by global alpha
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod1_reg <= 16'(s_src_pixel[31:24]) * 16'(s_global_alpha);
            src1_reg  <= s_src_pixel[23:0];
            dst1_reg  <= s_dst_pixel;
        end
    end

    // Stage 2: divide by 255, weight source channels, weight dest alpha
    assign alpha2 = div255_16(prod1_reg);
    assign inv2   = CH_MAX - alpha2;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            alpha2_reg <= alpha2;
            dainv2_reg <= 16'(dst1_reg[31:24]) * 16'(inv2);
            for (int c = 0; c < NCH; c++) begin
                sp2_reg[c] <= 16'(src1_reg[c*8 +: 8]) * 16'(alpha2);
            end
            dst2_reg <= dst1_reg;
        end
    end

    // Stage 3: output alpha, destination channel products
    assign oa_sum = {1'b0, alpha2_reg} + {1'b0, div255_16(dainv2_reg)};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            byp3_reg <= (alpha2_reg == 8'd0);
            oa3_reg  <= oa_sum[8] ? CH_MAX : oa_sum[7:0];
            for (int c = 0; c < NCH; c++) begin
                dp3_reg[c] <= 24'(dst2_reg[c*8 +: 8]) * 24'(dainv2_reg);
                sp3_reg[c] <= sp2_reg[c];
            end
            dst3_reg <= dst2_reg;
        end
    end

    // Stage 4: estimate dp / 255 by reciprocal multiply, high by at most one
    always_ff @(posedge aclk) begin
        logic [39:0] rp;
        if (pipe_en) begin
            for (int c = 0; c < NCH; c++) begin
                rp = 40'(dp3_reg[c]) * 40'(RECIP_255);
                est4_reg[c] <= rp[RECIP_SHIFT +: 16];
                dp4_reg[c]  <= dp3_reg[c];
                sp4_reg[c]  <= sp3_reg[c];
            end
            byp4_reg <= byp3_reg;
            oa4_reg  <= oa3_reg;
            dst4_reg <= dst3_reg;
        end
    end

    // Stage 5: correct the estimate, form numerators, clamp divisor
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            dback4[c] = {est4_reg[c], 8'b0} - {8'b0, est4_reg[c]};
            dterm4[c] = (dback4[c] > dp4_reg[c]) ? est4_reg[c] - 16'd1 : est4_reg[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int c = 0; c < NCH; c++) begin
                num5_reg[c] <= NUM_W'(sp4_reg[c]) + NUM_W'(dterm4[c]);
            end
            dv5_reg  <= (oa4_reg == 8'd0) ? 8'd1 : oa4_reg;
            byp5_reg <= byp4_reg;
            oa5_reg  <= oa4_reg;
            dst5_reg <= dst4_reg;
        end
    end

    // Stages 6 to 9: per-channel divide by output alpha
    for (genvar c = 0; c < NCH; c++) begin : g_div
        aob_qdiv u_qdiv (
            .aclk  (aclk),
            .en    (pipe_en),
            .num_i (num5_reg[c]),
            .div_i (dv5_reg),
            .q_o   (q_out[c])
        );
    end

    // Carry bypass flag, alpha and destination beside the divider
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sbyp_reg[0] <= byp5_reg;
            soa_reg[0]  <= oa5_reg;
            sdst_reg[0] <= dst5_reg;
            for (int i = 1; i < DIV_STAGES; i++) begin
                sbyp_reg[i] <= sbyp_reg[i-1];
                soa_reg[i]  <= soa_reg[i-1];
                sdst_reg[i] <= sdst_reg[i-1];
            end
        end
    end

    // Pick destination pass-through or the blended pixel
    assign m_out_pixel = sbyp_reg[DIV_STAGES-1] ? sdst_reg[DIV_STAGES-1]
                       : {soa_reg[DIV_STAGES-1], q_out[2], q_out[1], q_out[0]};

    // Checks
    `AOB_ASSERT_IMPLIES(a_est_fix, aclk, aresetn,
        v4_reg, ({dterm4[0], 8'b0} - {8'b0, dterm4[0]}) <= dp4_reg[0]
            && (dp4_reg[0] - ({dterm4[0], 8'b0} - {8'b0, dterm4[0]})) < 24'd255,
        "reciprocal correction off by more than one")
    `AOB_ASSERT_NEXT(a_oa_nonzero, aclk, aresetn,
        v3_reg && pipe_en && !byp3_reg, oa4_reg != 8'd0,
        "blended request with zero output alpha")
    `AOB_ASSERT_IMPLIES(a_out_alpha, aclk, aresetn,
        m_valid && !sbyp_reg[DIV_STAGES-1], m_out_pixel[31:24] != 8'd0,
        "blended result leaves with zero alpha")

endmodule

FILE: sv/aob_qdiv.sv
// Pipelined restoring divider: 17-bit numerator by 8-bit divisor, quotient
// saturated at 255, two quotient bits per stage. Depends on aob_pkg.
module aob_qdiv (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [aob_pkg::NUM_W-1:0] num_i,
    input  logic [7:0]                div_i,
    output logic [7:0]                q_o
);
    import aob_pkg::*;

    logic [NUM_W-1:0] rem_reg [DIV_STAGES];
    logic [7:0]       dvs_reg [DIV_STAGES];
    logic [7:0]       q_reg   [DIV_STAGES];
    logic             sat_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        localparam int B = 7 - 2 * s;
        logic [NUM_W-1:0] rem_in;
        logic [NUM_W-1:0] rem_next;
        logic [NUM_W-1:0] dext;
        logic [7:0]       dvs_in;
        logic [7:0]       q_in;
        logic [7:0]       q_next;
        logic             sat_in;

        // Pick up the previous stage, or the raw request at the first
        if (s == 0) begin : g_first
            assign rem_in = num_i;
            assign dvs_in = div_i;
            assign q_in   = '0;
            assign sat_in = (num_i >= {1'b0, div_i, 8'b0});
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign sat_in = sat_reg[s-1];
        end

        assign dext = {{(NUM_W-8){1'b0}}, dvs_in};

        // Two restoring steps: trial subtract of the shifted divisor
        always_comb begin
            rem_next = rem_in;
            q_next   = q_in;
            if (rem_next >= (dext << B)) begin
                rem_next  = rem_next - (dext << B);
                q_next[B] = 1'b1;
            end
            if (rem_next >= (dext << (B - 1))) begin
                rem_next      = rem_next - (dext << (B - 1));
                q_next[B - 1] = 1'b1;
            end
        end

        // Advance only when the pipeline moves
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                dvs_reg[s] <= dvs_in;
                q_reg[s]   <= q_next;
                sat_reg[s] <= sat_in;
            end
        end
    end

    // Clamp quotients that overflow eight bits
    assign q_o = sat_reg[DIV_STAGES-1] ? CH_MAX : q_reg[DIV_STAGES-1];

endmodule
